/* rtl/epsc_pkg.sv */
package epsc_pkg;

  // store sizes
  localparam int unsigned EXPR_DEPTH   = 4096;
  localparam int unsigned CLAUSE_DEPTH = 4096;
  localparam int unsigned LIST_COUNT   = 1024;
  localparam int unsigned LIST_MAX_LEN = 8;

  // field widths
  localparam int unsigned ID_W  = 12;
  localparam int unsigned LST_W = 10;

  // derived address and length widths
  localparam int unsigned EAW    = $clog2(EXPR_DEPTH);
  localparam int unsigned CAW    = $clog2(CLAUSE_DEPTH);
  localparam int unsigned LLAW   = $clog2(LIST_COUNT);
  localparam int unsigned LE_DEP = LIST_COUNT * LIST_MAX_LEN;
  localparam int unsigned LEAW   = $clog2(LE_DEP);
  localparam int unsigned LEN_W  = $clog2(LIST_MAX_LEN + 1);

  typedef enum logic [2:0] {
    OP_WR_EXPR   = 3'd0,
    OP_WR_CLAUSE = 3'd1,
    OP_WR_ELEM   = 3'd2,
    OP_WR_LEN    = 3'd3,
    OP_CHECK     = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    K_OTHER  = 3'd0,
    K_EQ     = 3'd1,
    K_NOT    = 3'd2,
    K_OR     = 3'd3,
    K_APPLY  = 3'd4,
    K_NAPPLY = 3'd5,
    K_TRUE   = 3'd6,
    K_FALSE  = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    R_SYMM        = 4'd0,
    R_NEG_SYMM    = 4'd1,
    R_RES_SYMM    = 4'd2,
    R_REFL        = 4'd3,
    R_RES_REFL    = 4'd4,
    R_TRANS       = 4'd5,
    R_RES_TRANS   = 4'd6,
    R_CONG        = 4'd7,
    R_RES_CONG    = 4'd8,
    R_TRUE_INTRO  = 4'd9,
    R_TRUE_ELIM   = 4'd10,
    R_FALSE_INTRO = 4'd11,
    R_FALSE_ELIM  = 4'd12
  } rule_e;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   a1;
    logic [ID_W-1:0]   a2;
    logic [LST_W-1:0]  lst;
    logic [ID_W-1:0]   func;
  } node_t;

  // flat list element address
  function automatic logic [LEAW-1:0] le_addr(input int unsigned lst, input int unsigned pos);
    return LEAW'(lst * LIST_MAX_LEN + pos);
  endfunction

  function automatic logic le_oob(input int unsigned lst, input int unsigned pos);
    return (lst >= LIST_COUNT) || (pos >= LIST_MAX_LEN);
  endfunction

endpackage

/* rtl/equality_proof_step_checker.sv */
// channel  | ports                                            | direction
// ---------+--------------------------------------------------+----------
// command  | start_i, busy_o, opcode_i .. premise_second_i    | in; busy_o out
// result   | done_o, was_check_o, step_passed_o               | out
//
// a write beat leaves busy_o low; its ack strobes next cycle.
// a check walks dependent reads through the single read port of the expression
// store; for the resolution list rules and n-ary congruence it then also walks
// the list pairs.
// reset clears only the sequencer and the strobe; stores are undefined until written.
// the receiver cannot stall: done_o is high for exactly one cycle per beat.
module equality_proof_step_checker
  import epsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        opcode_i,
  input  logic [11:0]       addr_i,
  input  logic [2:0]        node_kind_i,
  input  logic [11:0]       first_arg_i,
  input  logic [11:0]       second_arg_i,
  input  logic [9:0]        list_ref_i,
  input  logic [11:0]       func_var_i,
  input  logic [2:0]        list_pos_i,
  input  logic [3:0]        rule_i,
  input  logic [11:0]       premise_first_i,
  input  logic [11:0]       premise_second_i,
  output logic              done_o,
  output logic              was_check_o,
  output logic              step_passed_o
);

  typedef enum logic [19:0] {
    S_IDLE = 20'd1,
    S_P1   = 20'd1 << 1,
    S_P2   = 20'd1 << 2,
    S_P3   = 20'd1 << 3,
    S_P4   = 20'd1 << 4,
    S_P5   = 20'd1 << 5,
    S_P6   = 20'd1 << 6,
    S_P7   = 20'd1 << 7,
    S_P8   = 20'd1 << 8,
    S_P9   = 20'd1 << 9,
    S_F1   = 20'd1 << 10,
    S_F2   = 20'd1 << 11,
    S_S1   = 20'd1 << 12,
    S_S2   = 20'd1 << 13,
    S_L0   = 20'd1 << 14,
    S_L1   = 20'd1 << 15,
    S_L2   = 20'd1 << 16,
    S_L3   = 20'd1 << 17,
    S_L4   = 20'd1 << 18,
    S_FIN  = 20'd1 << 19
  } state_e;

  state_e state_q, state_d;

  logic accept;
  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // store ports
  logic             e_we, c_we, le_we, ll_we;
  logic [$bits(node_t)-1:0] e_rdata;
  logic [ID_W-1:0]  c_rdata;
  logic [ID_W-1:0]  le_rdata;
  logic [LEN_W-1:0] ll_rdata;
  node_t            e_wnode;
  logic [LEN_W-1:0] ll_wdata;

  // read requests from the sequencer
  logic [ID_W-1:0]  e_id, c_id;
  logic [LST_W-1:0] ll_id, le_lst;
  logic [LEN_W-1:0] le_pos;
  logic e_oob_q, c_oob_q, ll_oob_q, le_oob_q;

  // read data, zero when the index lay beyond the store
  node_t            e_d;
  logic [ID_W-1:0]  c_d, le_d;
  logic [LEN_W-1:0] ll_d;
  assign e_d  = e_oob_q  ? '0 : node_t'(e_rdata);
  assign c_d  = c_oob_q  ? '0 : c_rdata;
  assign le_d = le_oob_q ? '0 : le_rdata;
  assign ll_d = ll_oob_q ? '0 : ll_rdata;

  // write decode
  assign e_we  = accept && (opcode_i == OP_WR_EXPR) && (int'(addr_i) < EXPR_DEPTH);
  assign c_we  = accept && (opcode_i == OP_WR_CLAUSE) && (int'(addr_i) < CLAUSE_DEPTH);
  assign le_we = accept && (opcode_i == OP_WR_ELEM) && !le_oob(addr_i, list_pos_i);
  assign ll_we = accept && (opcode_i == OP_WR_LEN) && (int'(addr_i) < LIST_COUNT);

  assign e_wnode = '{kind: kind_e'(node_kind_i), a1: first_arg_i, a2: second_arg_i,
                     lst: list_ref_i, func: func_var_i};
  assign ll_wdata = (int'(first_arg_i) > LIST_MAX_LEN) ? LEN_W'(LIST_MAX_LEN)
                                                         : LEN_W'(first_arg_i);

  epsc_ram #(.WIDTH($bits(node_t)), .DEPTH(EXPR_DEPTH)) u_expr (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (EAW'(addr_i)),
    .wdata_i (e_wnode),
    .raddr_i (EAW'(e_id)),
    .rdata_o (e_rdata)
  );

  epsc_ram #(.WIDTH(ID_W), .DEPTH(CLAUSE_DEPTH)) u_clause (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (CAW'(addr_i)),
    .wdata_i (first_arg_i),
    .raddr_i (CAW'(c_id)),
    .rdata_o (c_rdata)
  );

  epsc_ram #(.WIDTH(ID_W), .DEPTH(LE_DEP)) u_elem (
    .clk_i   (clk_i),
    .we_i    (le_we),
    .waddr_i (le_addr(addr_i, list_pos_i)),
    .wdata_i (first_arg_i),
    .raddr_i (le_addr(le_lst, le_pos)),
    .rdata_o (le_rdata)
  );

  epsc_ram #(.WIDTH(LEN_W), .DEPTH(LIST_COUNT)) u_len (
    .clk_i   (clk_i),
    .we_i    (ll_we),
    .waddr_i (LLAW'(addr_i)),
    .wdata_i (ll_wdata),
    .raddr_i (LLAW'(ll_id)),
    .rdata_o (ll_rdata)
  );

  // range flags travel with the read
  always_ff @(posedge clk_i) begin
    e_oob_q  <= (int'(e_id) >= EXPR_DEPTH);
    c_oob_q  <= (int'(c_id) >= CLAUSE_DEPTH);
    ll_oob_q <= (int'(ll_id) >= LIST_COUNT);
    le_oob_q <= le_oob(le_lst, le_pos);
  end

  // check context
  rule_e            rule_q;
  logic [ID_W-1:0]  pc0_q, pc1_q, rid_q, pid_q, el0_q, fa_q;
  node_t            r_q, p_q, q_q, x1_q, x2_q, x3_q, x4_q, e0_q, f1_q, f2_q, eq_q;
  node_t            eq1_q, eq2_q;
  kind_e            ng_kind_q;
  logic [LEN_W-1:0] n_q, s1_q, k_q, k_last;
  logic             pre_q, neg_ok_q, match_ok_q, pre_ok;

  // read address selection
  always_comb begin
    e_id   = '0;
    c_id   = addr_i;
    ll_id  = '0;
    le_lst = '0;
    le_pos = '0;
    unique case (state_q)
      S_IDLE: c_id = addr_i;
      S_P1: begin
        e_id = c_d;
        c_id = pc0_q;
      end
      S_P2: begin
        e_id = c_d;
        c_id = pc1_q;
      end
      S_P3: e_id = c_d;
      S_P4: begin
        e_id   = r_q.a1;
        ll_id  = r_q.lst;
        le_lst = r_q.lst;
      end
      S_P5: e_id = r_q.a2;
      S_P6: e_id = p_q.a1;
      S_P7: e_id = p_q.a2;
      S_P8: e_id = el0_q;
      S_P9: e_id = e_d.a1;
      S_F1: e_id = e0_q.a2;
      S_F2: ll_id = f1_q.lst;
      S_S1: ll_id = f2_q.lst;
      S_S2: e_id = '0;
      S_L0: begin
        le_lst = r_q.lst;
        le_pos = k_q;
      end
      S_L1: e_id = le_d;
      S_L2: begin
        e_id   = e_d.a1;
        le_lst = f1_q.lst;
        le_pos = k_q - LEN_W'(1);
      end
      S_L3: begin
        le_lst = f2_q.lst;
        le_pos = k_q - LEN_W'(1);
      end
      S_L4: e_id = '0;
      S_FIN: e_id = '0;
      default: e_id = '0;
    endcase
  end

  // n-ary congruence preconditions, checked once the arg counts are in
  assign pre_ok = (r_q.kind == K_OR) && (n_q != '0) && (e0_q.kind == K_EQ) &&
                  (f1_q.kind == K_NAPPLY) && (f2_q.kind == K_NAPPLY) &&
                  (s1_q == ll_d) && (f1_q.func == f2_q.func) &&
                  ({1'b0, s1_q} + (LEN_W + 1)'(1) == {1'b0, n_q});

  // last list pair visited
  always_comb begin
    case (rule_q)
      R_RES_SYMM:  k_last = LEN_W'(1);
      R_RES_TRANS: k_last = LEN_W'(2);
      default:     k_last = s1_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept && (opcode_i == OP_CHECK)) state_d = S_P1;
      S_P1: state_d = S_P2;
      S_P2: state_d = S_P3;
      S_P3: state_d = S_P4;
      S_P4: state_d = S_P5;
      S_P5: state_d = S_P6;
      S_P6: state_d = S_P7;
      S_P7: state_d = S_P8;
      S_P8: state_d = S_P9;
      S_P9: begin
        if (rule_q == R_RES_CONG) begin
          state_d = S_F1;
        end else if ((rule_q == R_RES_SYMM) || (rule_q == R_RES_TRANS)) begin
          state_d = S_L0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_F1: state_d = S_F2;
      S_F2: state_d = S_S1;
      S_S1: state_d = S_S2;
      S_S2: state_d = (pre_ok && (s1_q != '0)) ? S_L0 : S_FIN;
      S_L0: state_d = S_L1;
      S_L1: state_d = S_L2;
      S_L2: state_d = S_L3;
      S_L3: state_d = S_L4;
      S_L4: state_d = (k_q == k_last) ? S_FIN : S_L0;
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture read data along the walk
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rule_q <= rule_e'(rule_i);
        pc0_q  <= premise_first_i;
        pc1_q  <= premise_second_i;
      end
      S_P1: rid_q <= c_d;
      S_P2: begin
        r_q   <= e_d;
        pid_q <= c_d;
      end
      S_P3: p_q <= e_d;
      S_P4: q_q <= e_d;
      S_P5: begin
        x1_q  <= e_d;
        n_q   <= ll_d;
        el0_q <= le_d;
      end
      S_P6: x2_q <= e_d;
      S_P7: x3_q <= e_d;
      S_P8: x4_q <= e_d;
      S_P9: begin
        e0_q       <= e_d;
        k_q        <= LEN_W'(1);
        neg_ok_q   <= 1'b1;
        match_ok_q <= 1'b1;
      end
      S_F1: f1_q <= e_d;
      S_F2: f2_q <= e_d;
      S_S1: s1_q <= ll_d;
      S_S2: begin
        pre_q      <= pre_ok;
        k_q        <= LEN_W'(1);
        neg_ok_q   <= 1'b1;
        match_ok_q <= 1'b1;
      end
      S_L0: ng_kind_q <= K_OTHER;
      S_L1: ng_kind_q <= K_OTHER;
      S_L2: ng_kind_q <= e_d.kind;
      S_L3: begin
        eq_q <= e_d;
        fa_q <= le_d;
      end
      S_L4: begin
        neg_ok_q   <= neg_ok_q && (ng_kind_q == K_NOT) && (eq_q.kind == K_EQ);
        match_ok_q <= match_ok_q && (eq_q.a1 == fa_q) && (eq_q.a2 == le_d);
        if (k_q == LEN_W'(1)) eq1_q <= eq_q;
        if (k_q == LEN_W'(2)) eq2_q <= eq_q;
        k_q <= k_q + LEN_W'(1);
      end
      S_FIN: pre_q <= pre_q;
      default: pre_q <= pre_q;
    endcase
  end

  // rule evaluation over the gathered nodes
  logic pass;
  always_comb begin
    case (rule_q)
      R_SYMM: pass = (r_q.kind == K_EQ) && (p_q.kind == K_EQ) &&
                     (r_q.a1 == p_q.a2) && (r_q.a2 == p_q.a1);
      R_NEG_SYMM: pass = (r_q.kind == K_NOT) && (p_q.kind == K_NOT) &&
                         (x1_q.a1 == x3_q.a2) && (x1_q.a2 == x3_q.a1);
      R_RES_SYMM: pass = (r_q.kind == K_OR) && (n_q == LEN_W'(2)) && neg_ok_q &&
                         (e0_q.kind == K_EQ) && (e0_q.a1 == eq1_q.a2) &&
                         (e0_q.a2 == eq1_q.a1);
      R_REFL: pass = (r_q.kind == K_EQ) && (r_q.a1 == r_q.a2);
      R_RES_REFL: pass = (r_q.kind == K_OR) && (n_q == LEN_W'(1)) &&
                         (e0_q.kind == K_EQ) && (e0_q.a1 == e0_q.a2);
      R_TRANS: pass = (r_q.kind == K_EQ) && (p_q.kind == K_EQ) && (q_q.kind == K_EQ) &&
                      (p_q.a2 == q_q.a1) && (r_q.a1 == p_q.a1) && (r_q.a2 == q_q.a2);
      R_RES_TRANS: pass = (r_q.kind == K_OR) && (n_q == LEN_W'(3)) && neg_ok_q &&
                          (e0_q.kind == K_EQ) && (e0_q.a1 == eq1_q.a1) &&
                          (e0_q.a2 == eq2_q.a2) && (eq1_q.a2 == eq2_q.a1);
      R_CONG: pass = (x1_q.a1 == p_q.a1) && (x2_q.a1 == p_q.a2) &&
                     (x1_q.a2 == q_q.a1) && (x2_q.a2 == q_q.a2) &&
                     (r_q.kind == K_EQ) && (x1_q.kind == K_APPLY) &&
                     (x2_q.kind == K_APPLY) && (p_q.kind == K_EQ) && (q_q.kind == K_EQ);
      R_RES_CONG: pass = pre_q && neg_ok_q && match_ok_q;
      R_TRUE_INTRO: pass = (x2_q.kind == K_TRUE) && (r_q.kind == K_EQ) &&
                           (pid_q == r_q.a1);
      R_TRUE_ELIM: pass = (p_q.kind == K_EQ) && (p_q.a1 == rid_q) &&
                          (x4_q.kind == K_TRUE);
      R_FALSE_INTRO: pass = (x2_q.kind == K_FALSE) && (r_q.kind == K_EQ) &&
                            (p_q.kind == K_NOT) && (p_q.a1 == r_q.a1);
      R_FALSE_ELIM: pass = (r_q.kind == K_NOT) && (x4_q.kind == K_FALSE) &&
                           (p_q.kind == K_EQ) && (p_q.a1 == r_q.a1);
      default: pass = 1'b0;
    endcase
  end

  // result strobe
  logic done_q, was_check_q, passed_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (accept && (opcode_i != OP_CHECK)) || (state_q == S_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    was_check_q <= (state_q == S_FIN);
    passed_q    <= (state_q == S_FIN) && pass;
  end

  assign done_o        = done_q;
  assign was_check_o   = was_check_q;
  assign step_passed_o = passed_q;

endmodule

/* rtl/epsc_ram.sv */
module epsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
